// File: sv/lsfit_pkg.sv
// ----------------------------------------------------------------------------
// Least-squares line fit package
// Payload types, status codes and fixed constants shared by the fit block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsfit_pkg;

  localparam int unsigned COORD_W = 24;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_DROP = 2'd3;

  localparam logic [62:0] RES_CAP = {63{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x_value;
    logic signed [COORD_W-1:0] y_value;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] slope_out;
    logic signed [31:0] intercept_out;
    logic [62:0]        residual_sum;
    logic [6:0]         point_count;
    logic [1:0]         fit_status;
  } fit_t;

endpackage

// File: sv/lsfit_ram.sv
// ----------------------------------------------------------------------------
// Point store RAM
// Simple dual-port RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsfit_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/least_squares_line_fit.sv
// ----------------------------------------------------------------------------
// Least-squares line fit
// Collects signed Q12.12 points, fits y = slope*x + intercept and reports the
// residual sum of squares.
//
// Usage: each request on the point channel carries one (x, y) point. A point
// that is not marked last is stored and accumulated as it is taken, and
// point_ready stays high. A point marked last closes the set: point_ready
// drops while one shared 128-bit add/subtract unit runs the fit as a series
// of shift-add multiplies and restoring divides. After the fit, a residual
// pass runs for each stored point: a RAM read, one 32x24 multiply and one
// 64-iteration square on the shared unit.
// The result sits in an output register until fit_ready takes it. Points not
// marked last are still accepted while it waits; a following fit holds its
// result until the register is free. Points beyond MAX_POINTS are dropped and
// flagged. Reset clears the sums, the count and the output valid; the point
// store needs no clearing since only entries of the current set are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_squares_line_fit import lsfit_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   point_valid,
  output logic   point_ready,
  input  point_t point,
  output logic   fit_valid,
  input  logic   fit_ready,
  output fit_t   fit
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW = COORD_W + CW;
  localparam int PW = 2 * COORD_W + CW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_T1    = 5'd1;
  localparam logic [4:0] S_T2    = 5'd2;
  localparam logic [4:0] S_NUM   = 5'd3;
  localparam logic [4:0] S_T1B   = 5'd4;
  localparam logic [4:0] S_T2B   = 5'd5;
  localparam logic [4:0] S_DEN   = 5'd6;
  localparam logic [4:0] S_SLOPE = 5'd7;
  localparam logic [4:0] S_T3    = 5'd8;
  localparam logic [4:0] S_DIFF  = 5'd9;
  localparam logic [4:0] S_ICPT  = 5'd10;
  localparam logic [4:0] S_RD    = 5'd11;
  localparam logic [4:0] S_RX    = 5'd12;
  localparam logic [4:0] S_RR    = 5'd13;
  localparam logic [4:0] S_SQ    = 5'd14;
  localparam logic [4:0] S_OUT   = 5'd15;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_MNEG = 3'd2;
  localparam logic [2:0] U_DABS = 3'd3;
  localparam logic [2:0] U_DIV  = 3'd4;

  // Truncate toward zero and saturate a divide result to 32 bits.
  function automatic logic [32:0] div_sat(input logic [127:0] qv, input logic negv);
    logic [32:0] r;
    if (negv) begin
      if (qv[127:32] != '0 || qv[31:0] > 32'h8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'd0 - qv[31:0]};
      end
    end else begin
      if (qv[127:31] != '0) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, qv[31:0]};
      end
    end
    return r;
  endfunction

  logic [4:0]           state;
  logic                 launched;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic                 dropped;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [PW-1:0] sum_xy;
  logic signed [PW-1:0] sum_xx;
  logic [127:0]         t1;
  logic [127:0]         t2;
  logic [127:0]         numr;
  logic [127:0]         den;
  logic signed [31:0]   slope;
  logic signed [31:0]   icpt;
  logic                 zero;
  logic                 sat;
  logic [62:0]          res;
  logic signed [55:0]   px;
  logic signed [23:0]   ry;
  logic [63:0]          rr;

  // shared unit
  logic [2:0]   u_phase;
  logic [127:0] ua;
  logic [127:0] ub;
  logic [127:0] acc;
  logic [127:0] q;
  logic [6:0]   cnt;
  logic         u_neg;
  logic         u_done;
  logic         u_start;
  logic         u_use;
  logic [1:0]   u_op;
  logic [127:0] u_a;
  logic [127:0] u_b;
  logic [127:0] add_a;
  logic [127:0] add_b;
  logic         add_cin;
  logic [128:0] add_sum;
  logic [127:0] rsh;
  logic [63:0]  a_mag;
  logic [63:0]  b_mag;

  logic [47:0]          rdata;
  logic                 take;
  logic signed [47:0]   pxy;
  logic signed [47:0]   pxx;
  logic [63:0]          sx64;
  logic [63:0]          sy64;
  logic [63:0]          sxy64;
  logic [63:0]          sxx64;
  logic [63:0]          n64;
  logic [32:0]          dsat;
  logic [64:0]          rsum;
  logic                 rover;
  logic [1:0]           status;

  assign point_ready = (state == S_IDLE);
  assign take        = point_valid && point_ready;
  assign pxy         = point.x_value * point.y_value;
  assign pxx         = point.x_value * point.x_value;

  assign sx64  = {{(64 - SW){sum_x[SW-1]}}, sum_x};
  assign sy64  = {{(64 - SW){sum_y[SW-1]}}, sum_y};
  assign sxy64 = {{(64 - PW){sum_xy[PW-1]}}, sum_xy};
  assign sxx64 = {{(64 - PW){sum_xx[PW-1]}}, sum_xx};
  assign n64   = {{(64 - CW){1'b0}}, count};

  lsfit_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (take && (count != CW'(MAX_POINTS))),
    .waddr (count[AW-1:0]),
    .wdata ({point.x_value, point.y_value}),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // Operation request for the shared unit, per sequencer state.
  always_comb begin
    u_use = 1'b1;
    u_op  = OP_MUL;
    u_a   = '0;
    u_b   = '0;
    case (state)
      S_T1: begin
        u_a = {64'd0, sx64};
        u_b = {64'd0, sy64};
      end
      S_T2: begin
        u_a = {64'd0, n64};
        u_b = {64'd0, sxy64};
      end
      S_NUM, S_DEN: begin
        u_op = OP_SUB;
        u_a  = t1;
        u_b  = t2;
      end
      S_T1B: begin
        u_a = {64'd0, sx64};
        u_b = {64'd0, sx64};
      end
      S_T2B: begin
        u_a = {64'd0, n64};
        u_b = {64'd0, sxx64};
      end
      S_SLOPE: begin
        u_op = OP_DIV;
        u_a  = {numr[111:0], 16'd0};
        u_b  = den;
      end
      S_T3: begin
        u_a = {64'd0, {32{slope[31]}}, slope};
        u_b = {64'd0, sx64};
      end
      S_DIFF: begin
        u_op = OP_SUB;
        u_a  = {{(112 - SW){sum_y[SW-1]}}, sum_y, 16'd0};
        u_b  = t1;
      end
      S_ICPT: begin
        u_op = OP_DIV;
        u_a  = numr;
        u_b  = {{(116 - CW){1'b0}}, count, 12'd0};
      end
      S_SQ: begin
        u_a = {64'd0, rr};
        u_b = {64'd0, rr};
      end
      default: begin
        u_use = 1'b0;
      end
    endcase
  end

  assign u_start = u_use && !launched;
  assign a_mag   = u_a[63] ? 64'd0 - u_a[63:0] : u_a[63:0];
  assign b_mag   = u_b[63] ? 64'd0 - u_b[63:0] : u_b[63:0];
  assign rsh     = {acc[126:0], ua[127]};

  // The single 128-bit adder that all shared-unit operations use.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (u_phase)
      U_IDLE: begin
        if (u_op == OP_SUB) begin
          add_a   = u_a;
          add_b   = ~u_b;
          add_cin = 1'b1;
        end else begin
          add_a   = ~u_a;
          add_cin = 1'b1;
        end
      end
      U_MUL: begin
        add_a = acc;
        add_b = ub[0] ? ua : '0;
      end
      U_MNEG: begin
        add_a   = ~acc;
        add_cin = 1'b1;
      end
      U_DABS: begin
        add_a   = ~ub;
        add_cin = 1'b1;
      end
      U_DIV: begin
        add_a   = rsh;
        add_b   = ~ub;
        add_cin = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {128'd0, add_cin};

  always_ff @(posedge clk) begin
    if (rst) begin
      u_phase <= U_IDLE;
      u_done  <= 1'b0;
    end else begin
      u_done <= 1'b0;
      case (u_phase)
        U_IDLE: begin
          if (u_start) begin
            case (u_op)
              OP_MUL: begin
                ua      <= {64'd0, a_mag};
                ub      <= {64'd0, b_mag};
                acc     <= '0;
                u_neg   <= u_a[63] ^ u_b[63];
                cnt     <= '0;
                u_phase <= U_MUL;
              end
              OP_DIV: begin
                ua      <= u_a[127] ? add_sum[127:0] : u_a;
                ub      <= u_b;
                u_neg   <= u_a[127] ^ u_b[127];
                acc     <= '0;
                q       <= '0;
                cnt     <= '0;
                u_phase <= U_DABS;
              end
              default: begin
                acc    <= add_sum[127:0];
                u_done <= 1'b1;
              end
            endcase
          end
        end
        U_MUL: begin
          acc <= add_sum[127:0];
          ua  <= {ua[126:0], 1'b0};
          ub  <= {1'b0, ub[127:1]};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            if (u_neg) begin
              u_phase <= U_MNEG;
            end else begin
              u_phase <= U_IDLE;
              u_done  <= 1'b1;
            end
          end
        end
        U_MNEG: begin
          acc     <= add_sum[127:0];
          u_phase <= U_IDLE;
          u_done  <= 1'b1;
        end
        U_DABS: begin
          if (ub[127]) begin
            ub <= add_sum[127:0];
          end
          u_phase <= U_DIV;
        end
        U_DIV: begin
          acc <= add_sum[128] ? add_sum[127:0] : rsh;
          q   <= {q[126:0], add_sum[128]};
          ua  <= {ua[126:0], 1'b0};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) begin
            u_phase <= U_IDLE;
            u_done  <= 1'b1;
          end
        end
        default: begin
          u_phase <= U_IDLE;
        end
      endcase
    end
  end

  assign dsat  = div_sat(q, u_neg);
  assign rsum  = {1'b0, acc[95:32]} + {2'b00, res};
  assign rover = (acc[127:96] != '0) || (rsum[64:63] != 2'b00);

  always_comb begin
    if (dropped) begin
      status = ST_DROP;
    end else if (zero) begin
      status = ST_ZERO;
    end else if (sat) begin
      status = ST_SAT;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      count     <= '0;
      idx       <= '0;
      dropped   <= 1'b0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_xy    <= '0;
      sum_xx    <= '0;
      zero      <= 1'b0;
      sat       <= 1'b0;
      res       <= '0;
      fit_valid <= 1'b0;
    end else begin
      // In S_OUT the output register is loaded by the state itself, or held while the old result waits.
      if (fit_valid && fit_ready && state != S_OUT) begin
        fit_valid <= 1'b0;
      end
      if (u_start) begin
        launched <= 1'b1;
      end
      if (u_done) begin
        launched <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            if (count != CW'(MAX_POINTS)) begin
              sum_x  <= sum_x + SW'(point.x_value);
              sum_y  <= sum_y + SW'(point.y_value);
              sum_xy <= sum_xy + PW'(pxy);
              sum_xx <= sum_xx + PW'(pxx);
              count  <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (point.last_point) begin
              state <= S_T1;
            end
          end
        end
        S_T1: if (u_done) begin
          t1    <= acc;
          state <= S_T2;
        end
        S_T2: if (u_done) begin
          t2    <= acc;
          state <= S_NUM;
        end
        S_NUM: if (u_done) begin
          numr  <= acc;
          state <= S_T1B;
        end
        S_T1B: if (u_done) begin
          t1    <= acc;
          state <= S_T2B;
        end
        S_T2B: if (u_done) begin
          t2    <= acc;
          state <= S_DEN;
        end
        S_DEN: if (u_done) begin
          den <= acc;
          if (acc == '0) begin
            zero  <= 1'b1;
            slope <= '0;
            state <= S_T3;
          end else begin
            state <= S_SLOPE;
          end
        end
        S_SLOPE: if (u_done) begin
          slope <= dsat[31:0];
          sat   <= sat | dsat[32];
          state <= S_T3;
        end
        S_T3: if (u_done) begin
          t1    <= acc;
          state <= S_DIFF;
        end
        S_DIFF: if (u_done) begin
          numr  <= acc;
          state <= S_ICPT;
        end
        S_ICPT: if (u_done) begin
          icpt  <= dsat[31:0];
          sat   <= sat | dsat[32];
          idx   <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_RX;
        end
        S_RX: begin
          px    <= slope * $signed(rdata[47:24]);
          ry    <= rdata[23:0];
          state <= S_RR;
        end
        S_RR: begin
          rr <= {{24{ry[23]}}, ry, 16'd0} - {{8{px[55]}}, px}
                - {{20{icpt[31]}}, icpt, 12'd0};
          state <= S_SQ;
        end
        S_SQ: if (u_done) begin
          if (rover) begin
            res <= RES_CAP;
            sat <= 1'b1;
          end else begin
            res <= rsum[62:0];
          end
          idx <= idx + CW'(1);
          if (idx + CW'(1) == count) begin
            state <= S_OUT;
          end else begin
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!fit_valid || fit_ready) begin
            fit_valid         <= 1'b1;
            fit.slope_out     <= slope;
            fit.intercept_out <= icpt;
            fit.residual_sum  <= res;
            fit.point_count   <= 7'(count);
            fit.fit_status    <= status;
            sum_x   <= '0;
            sum_y   <= '0;
            sum_xy  <= '0;
            sum_xx  <= '0;
            count   <= '0;
            dropped <= 1'b0;
            zero    <= 1'b0;
            sat     <= 1'b0;
            res     <= '0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above capacity");

  a_unit_free: assert property (@(posedge clk) disable iff (rst)
    u_start |-> u_phase == U_IDLE)
    else $error("shared unit started while busy");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> idx < count)
    else $error("residual walk past stored points");

  a_fit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && take && point.last_point) |=> count != '0)
    else $error("fit started with no stored point");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Least-squares line fit testbench
// Sends sets of points through the point channel and checks each fit against
// a bit-exact predictor, with random gaps on both channels and one long hold
// on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lsfit_pkg::*;

  localparam int MAX_PTS     = 64;
  localparam int STALL_LIMIT = 30000;
  localparam int HOLD_CYCLES = 3000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   point_valid = 1'b0;
  logic   point_ready;
  point_t point = '0;
  logic   fit_valid;
  logic   fit_ready = 1'b0;
  fit_t   fit;

  least_squares_line_fit #(.MAX_POINTS(MAX_PTS)) dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_ready(point_ready), .point(point),
    .fit_valid(fit_valid), .fit_ready(fit_ready), .fit(fit)
  );

  always #6 clk = ~clk;

  point_t pending_points[$];
  fit_t   fits_due[$];
  int     errors = 0;
  int     points_taken = 0;
  int     fits_seen = 0;
  int     n_drop = 0, n_zero = 0, n_sat = 0;

  // Running sums and point store of the set being collected.
  longint            acc_x, acc_y, acc_xy, acc_xx;
  int                acc_n;
  logic              acc_dropped;
  logic signed [23:0] xs[MAX_PTS];
  logic signed [23:0] ys[MAX_PTS];

  function automatic logic [31:0] clamp32(input logic signed [127:0] q, inout logic sat);
    if (&q[127:31] || ~|q[127:31]) return q[31:0];
    sat = 1'b1;
    return q[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  task automatic fold_point(input point_t p);
    logic signed [127:0] sx, sy, sxy, sxx, nn, num, den, diff;
    logic signed [31:0]  slope, icpt;
    logic [127:0]        sq, res;
    logic [63:0]         mag;
    longint              r, lx, ly;
    logic                sat, zero;
    fit_t                f;
    lx = longint'(p.x_value);
    ly = longint'(p.y_value);
    if (acc_n < MAX_PTS) begin
      xs[acc_n] = p.x_value;
      ys[acc_n] = p.y_value;
      acc_x += lx;
      acc_y += ly;
      acc_xy += lx * ly;
      acc_xx += lx * lx;
      acc_n++;
    end else begin
      acc_dropped = 1'b1;
    end
    if (!p.last_point) return;
    sat = 1'b0;
    zero = 1'b0;
    slope = '0;
    sx = acc_x; sy = acc_y; sxy = acc_xy; sxx = acc_xx;
    nn = (acc_n == 0) ? 1 : acc_n;
    num = sx * sy - nn * sxy;
    den = sx * sx - nn * sxx;
    if (den == 0) zero = 1'b1;
    else slope = clamp32((num <<< 16) / den, sat);
    diff = (sy <<< 16) - 128'(slope) * sx;
    icpt = clamp32(diff / (nn * 4096), sat);
    res = '0;
    for (int i = 0; i < acc_n; i++) begin
      r = longint'(ys[i]) * 65536 - longint'(slope) * longint'(xs[i])
          - longint'(icpt) * 4096;
      mag = (r < 0) ? -r : r;
      sq = ({64'b0, mag} * {64'b0, mag}) >> 32;
      if (sq > {65'b0, RES_CAP} - res) begin
        res = {65'b0, RES_CAP};
        sat = 1'b1;
      end else begin
        res += sq;
      end
    end
    f.slope_out = slope;
    f.intercept_out = icpt;
    f.residual_sum = res[62:0];
    f.point_count = acc_n[6:0];
    if (acc_dropped) begin f.fit_status = ST_DROP; n_drop++; end
    else if (zero) begin f.fit_status = ST_ZERO; n_zero++; end
    else if (sat) begin f.fit_status = ST_SAT; n_sat++; end
    else f.fit_status = ST_OK;
    fits_due.push_back(f);
    acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
    acc_n = 0;
    acc_dropped = 1'b0;
  endtask

  function automatic logic signed [23:0] pick_coord(input int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8191)) - 4096);
      default: return 24'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  task automatic add_point(input int x, input int y, input logic last);
    point_t p;
    p.x_value = 24'(x);
    p.y_value = 24'(y);
    p.last_point = last;
    pending_points.push_back(p);
  endtask

  task automatic add_random_set(input int n);
    int mode, slope_q, base, x, y;
    mode = $urandom_range(0, 3);
    slope_q = $signed($urandom_range(0, 16383)) - 8192;
    base = $signed($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < n; i++) begin
      if (mode == 3) begin
        // Points near a straight line, so that residuals stay small.
        x = pick_coord(1);
        y = base + ((x * slope_q) >>> 12) + $signed($urandom_range(0, 63)) - 32;
      end else begin
        x = pick_coord(mode);
        y = pick_coord(mode);
      end
      add_point(x, y, i == n - 1);
    end
  endtask

  // Sender: one request at a time, held until it is accepted.
  always @(posedge clk) begin
    logic   nxt_valid;
    point_t nxt;
    nxt_valid = point_valid;
    nxt = point;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (point_valid && point_ready) begin
        fold_point(point);
        points_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_points.size() > 0 &&
          ((points_taken > 600 && points_taken < 1000) || $urandom_range(0, 99) >= 18)) begin
        nxt = pending_points.pop_front();
        nxt_valid = 1'b1;
      end
    end
    point_valid <= nxt_valid;
    point <= nxt;
  end

  // Receiver: random gaps, one long hold after a few fits.
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    logic rdy;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rdy = 1'b0;
    end else if (!hold_done && fits_seen == 15) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      rdy = 1'b0;
    end else begin
      rdy = (points_taken > 600 && points_taken < 1000) || $urandom_range(0, 99) >= 18;
    end
    fit_ready <= rdy;
  end

  always @(posedge clk) begin
    fit_t e;
    if (!rst && fit_valid && fit_ready) begin
      fits_seen++;
      if (fits_due.size() == 0) begin
        $error("fit result with no request pending");
        errors++;
      end else begin
        e = fits_due.pop_front();
        if (fit.slope_out !== e.slope_out) begin
          $error("slope_out: expected %0d, got %0d", e.slope_out, fit.slope_out);
          errors++;
        end
        if (fit.intercept_out !== e.intercept_out) begin
          $error("intercept_out: expected %0d, got %0d", e.intercept_out, fit.intercept_out);
          errors++;
        end
        if (fit.residual_sum !== e.residual_sum) begin
          $error("residual_sum: expected %0d, got %0d", e.residual_sum, fit.residual_sum);
          errors++;
        end
        if (fit.point_count !== e.point_count) begin
          $error("point_count: expected %0d, got %0d", e.point_count, fit.point_count);
          errors++;
        end
        if (fit.fit_status !== e.fit_status) begin
          $error("fit_status: expected %0d, got %0d", e.fit_status, fit.fit_status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  int quiet = 0;
  always @(posedge clk) begin
    if ((point_valid && point_ready) || (fit_valid && fit_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("** least_squares_line_fit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
    acc_n = 0;
    acc_dropped = 1'b0;
    // A single point has a zero denominator.
    add_point(0, 0, 1'b1);
    add_point(-8388608, 8388607, 1'b1);
    // Both extremes in one set.
    add_point(-8388608, 8388607, 1'b0);
    add_point(8388607, -8388608, 1'b1);
    // All x equal.
    add_point(4096, 100, 1'b0);
    add_point(4096, -9000, 1'b0);
    add_point(4096, 8388607, 1'b1);
    // Steep line: slope saturates.
    add_point(0, -8388608, 1'b0);
    add_point(1, 8388607, 1'b1);
    // Exact line y = 2x + 1.
    for (int i = 0; i < 4; i++) add_point(i * 4096, i * 8192 + 4096, i == 3);
    // Huge spread: residual sum can saturate.
    add_point(-8388608, -8388608, 1'b0);
    add_point(8388607, -8388608, 1'b0);
    add_point(0, 8388607, 1'b0);
    add_point(1, -8388608, 1'b1);
    while (pending_points.size() < 2000) begin
      // Mostly small sets; now and then a set near or past capacity.
      if ($urandom_range(0, 99) < 6) add_random_set($urandom_range(60, 72));
      else add_random_set($urandom_range(1, 10));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_points.size() == 0 && !point_valid);
    wait (fits_due.size() == 0);
    repeat (6000) @(posedge clk);
    $display("%0d points accepted, %0d fits checked", points_taken, fits_seen);
    $display("status seen: %0d dropped, %0d zero denominator, %0d saturated",
             n_drop, n_zero, n_sat);
    if (errors == 0 && fits_due.size() == 0) begin
      $display("** least_squares_line_fit: PASSED **");
    end else begin
      $display("** least_squares_line_fit: FAILED **");
    end
    $finish;
  end

endmodule
